// File: src/mgwc_pkg.sv
// ----------------------------------------------------------------------------
// mgwc_pkg
// Shared types, constants and codes of the motion gated window capture block.
// ----------------------------------------------------------------------------
package mgwc_pkg;

   localparam int WINDOW_MAX_DEF = 64;
   localparam int BATCH_MAX_DEF  = 16;

   localparam logic [31:0] READY_MIN_DWELL = 32'd4;

   // transaction kinds
   localparam logic [1:0] ACT_SAMPLE = 2'd0;
   localparam logic [1:0] ACT_ARM    = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   // register indexes
   localparam logic [2:0] REG_GRAVITY    = 3'd0;
   localparam logic [2:0] REG_START_THR  = 3'd1;
   localparam logic [2:0] REG_STOP_THR   = 3'd2;
   localparam logic [2:0] REG_STILL_BAT  = 3'd3;
   localparam logic [2:0] REG_STILL_HOLD = 3'd4;
   localparam logic [2:0] REG_REPOS_WAIT = 3'd5;
   localparam logic [2:0] REG_WIN_LEN    = 3'd6;

   // sequencer phases
   localparam logic [2:0] PH_PENDING = 3'd0;
   localparam logic [2:0] PH_STILL   = 3'd1;
   localparam logic [2:0] PH_READY   = 3'd2;
   localparam logic [2:0] PH_CAPTURE = 3'd3;
   localparam logic [2:0] PH_REPOS   = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic store_sample;  // write sample into batch store
      logic read_win;      // read window entry
      logic sqrt_start;    // start magnitude computation
      logic decide;        // run motion decision and phase step
      logic copy_start;    // copy start marker (the copy pointer is cleared on decide)
      logic copy_step;     // copy one triplet
      logic arm;           // set arm flag
      logic finish;        // transaction accepted: clear per-transaction flags
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic sqrt_done;
      logic copy_more;     // capture continues with another triplet
      logic batch_close;   // this sample closes a nonempty batch
   } stat_type;

endpackage

// File: src/motion_gated_window_capture.sv
// Response timing: arm, read, unused and mid-batch samples present their
// response the cycle after acceptance; a batch-closing sample passes through
// squaring, the 17-step root, the decision and the copy of each triplet (at
// most 16) before its response. One transaction in flight; the next is
// accepted the cycle after the response transaction.
// Reset: synchronous, active high; control registers return to their defaults; the stores are not reset.
// ----------------------------------------------------------------------------
// motion_gated_window_capture
// Motion gated gesture window capture with batch processing and readback.
// ----------------------------------------------------------------------------
module motion_gated_window_capture
   import mgwc_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int BATCH_MAX  = BATCH_MAX_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // sample_x, sample_y, sample_z, read_index, pad
   input  logic [1:0]  req_tuser,  // action
   input  logic        req_tlast,  // batch_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // read_x, read_y, read_z, captured_count, pad
   output logic [4:0]  rsp_tuser,  // phase, phase_changed, gesture_complete
   output logic        rsp_tlast,  // moving
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   cmd_type  cmd;
   stat_type stat;

   logic [14:0] gravity_ff;
   logic [15:0] start_ff, stop_ff;
   logic [9:0]  still_b_ff, hold_ff, repos_ff;
   logic [6:0]  wlen_ff;
   logic [47:0] rd_data;
   logic [2:0]  phase;
   logic        changed, done, moving;
   logic [6:0]  fill;

   assign csr_ready = 1'b1;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gravity_ff <= 15'd1000;
         start_ff   <= 16'd200;
         stop_ff    <= 16'd100;
         still_b_ff <= 10'd10;
         hold_ff    <= 10'd10;
         repos_ff   <= 10'd25;
         wlen_ff    <= 7'd50;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GRAVITY:    gravity_ff <= csr_data[14:0];
            REG_START_THR:  start_ff   <= csr_data;
            REG_STOP_THR:   stop_ff    <= csr_data;
            REG_STILL_BAT:  still_b_ff <= csr_data[9:0];
            REG_STILL_HOLD: hold_ff    <= csr_data[9:0];
            REG_REPOS_WAIT: repos_ff   <= csr_data[9:0];
            REG_WIN_LEN:    wlen_ff    <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   mgwc_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready,
      .req_action(req_tuser), .rsp_tvalid, .rsp_tready, .cmd, .stat
   );

   mgwc_dp #(.WINDOW_MAX(WINDOW_MAX), .BATCH_MAX(BATCH_MAX)) u_dp (
      .clock, .reset, .cmd, .stat,
      .req_batch_end(req_tlast),
      .req_x(req_tdata[15:0]), .req_y(req_tdata[31:16]), .req_z(req_tdata[47:32]),
      .req_index(req_tdata[53:48]),
      .gravity_mg(gravity_ff), .start_thr(start_ff), .stop_thr(stop_ff),
      .still_batches(still_b_ff), .still_hold(hold_ff), .repos_wait(repos_ff),
      .window_length(wlen_ff),
      .rd_data, .phase, .changed, .done, .moving, .fill
   );

   assign rsp_tdata = {1'b0, fill, rd_data};
   assign rsp_tuser = {done, changed, phase};
   assign rsp_tlast = moving;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while response pending");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (fill <= 7'(WINDOW_MAX))) else $error("window fill too large");
   a_done_repos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && done) |-> (phase == PH_REPOS && changed))
      else $error("completion outside reposition");
`endif

endmodule

// File: src/mgwc_ctrl.sv
// ----------------------------------------------------------------------------
// mgwc_ctrl
// Transaction sequencer: accepts one request, steps the datapath, then
// presents the response.
// ----------------------------------------------------------------------------
module mgwc_ctrl
   import mgwc_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  logic [1:0] req_action,
   output logic     rsp_tvalid,
   input  logic     rsp_tready,
   output cmd_type  cmd,
   input  stat_type stat
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SQRT   = 6'b000010,
      ST_DECIDE = 6'b000100,
      ST_COPY   = 6'b001000,
      ST_RESP   = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_RESP);
   assign accept     = req_tvalid && req_tready;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.store_sample = (req_action == ACT_SAMPLE);
               cmd.read_win     = (req_action == ACT_READ);
               cmd.arm          = (req_action == ACT_ARM);
               cmd.finish       = 1'b1;
               if (req_action == ACT_SAMPLE && stat.batch_close) begin
                  cmd.sqrt_start = 1'b1;
                  state_in       = ST_SQRT;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_SQRT: begin
            if (stat.sqrt_done) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            cmd.decide     = 1'b1;
            cmd.copy_start = 1'b1;
            state_in       = ST_COPY;
         end
         ST_COPY: begin
            if (stat.copy_more) begin
               cmd.copy_step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

// File: src/mgwc_dp.sv
// ----------------------------------------------------------------------------
// mgwc_dp
// Datapath: batch and window stores, iterative square root, motion
// hysteresis, phase timers and the copy pointer.
// ----------------------------------------------------------------------------
module mgwc_dp
   import mgwc_pkg::*;
#(
   parameter int WINDOW_MAX = WINDOW_MAX_DEF,
   parameter int BATCH_MAX  = BATCH_MAX_DEF
)(
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output stat_type    stat,
   input  logic        req_batch_end,
   input  logic [15:0] req_x,
   input  logic [15:0] req_y,
   input  logic [15:0] req_z,
   input  logic [5:0]  req_index,
   input  logic [14:0] gravity_mg,
   input  logic [15:0] start_thr,
   input  logic [15:0] stop_thr,
   input  logic [9:0]  still_batches,
   input  logic [9:0]  still_hold,
   input  logic [9:0]  repos_wait,
   input  logic [6:0]  window_length,
   output logic [47:0] rd_data,
   output logic [2:0]  phase,
   output logic        changed,
   output logic        done,
   output logic        moving,
   output logic [6:0]  fill
);

   localparam int BW = $clog2(BATCH_MAX + 1);
   localparam int BA = (BATCH_MAX > 1) ? $clog2(BATCH_MAX) : 1;
   localparam int WA = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

   logic [47:0] batch_mem [BATCH_MAX];
   logic [47:0] win_mem   [WINDOW_MAX];

   logic [BW-1:0] bfill_ff, bfill_in, nbatch_ff;
   logic [47:0]   last_ff;
   logic [2:0]    phase_ff;
   logic          moving_ff, armed_ff, changed_ff, done_ff;
   logic [9:0]    still_run_ff;
   logic [6:0]    fill_ff;
   logic [31:0]   tick_ff, still_t_ff, ready_t_ff, repos_t_ff;
   logic [BW-1:0] cptr_ff;
   logic          capt_ff;
   logic [47:0]   rd_ff;
   logic          cp_valid_ff;
   logic [6:0]    win_eff;

   // effective window length
   always_comb begin
      if (window_length == 7'd0) win_eff = 7'd1;
      else if ({25'd0, window_length} > WINDOW_MAX) win_eff = 7'(WINDOW_MAX);
      else win_eff = window_length;
   end

   // batch store fill
   logic room;
   assign room = ({{(32-BW){1'b0}}, bfill_ff} < BATCH_MAX);
   always_comb begin
      bfill_in = bfill_ff;
      if (cmd.store_sample && room) bfill_in = bfill_ff + 1'b1;
   end
   // a sample always leaves its batch nonempty, so its end mark closes it
   assign stat.batch_close = req_batch_end;

   always_ff @(posedge clock) begin
      if (cmd.store_sample && room) batch_mem[bfill_ff[BA-1:0]] <= {req_z, req_y, req_x};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bfill_ff <= '0;
      end else if (cmd.store_sample) begin
         bfill_ff <= stat.batch_close ? '0 : bfill_in;
      end
   end

   // newest triplet and batch size for processing
   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         nbatch_ff <= bfill_in;
         last_ff   <= room ? {req_z, req_y, req_x} : batch_mem[BA'(BATCH_MAX - 1)];
      end
   end

   // sum of squares, then one result bit per cycle
   logic signed [15:0] sx, sy, sz;
   logic [33:0] sumsq;
   assign sx = last_ff[15:0];
   assign sy = last_ff[31:16];
   assign sz = last_ff[47:32];

   logic [31:0] sq_x_ff, sq_y_ff, sq_z_ff;
   logic [2:0]  pre_ff;
   logic [33:0] rem_ff;
   logic [17:0] root_ff;
   logic [4:0]  sbit_ff;
   logic        srun_ff;
   assign sumsq = {2'b0, sq_x_ff} + {2'b0, sq_y_ff} + {2'b0, sq_z_ff};

   always_ff @(posedge clock) begin
      sq_x_ff <= 32'(sx * sx);
      sq_y_ff <= 32'(sy * sy);
      sq_z_ff <= 32'(sz * sz);
   end

   // restoring square root: 17 digit steps over a 34-bit radicand
   logic [33:0] rad_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         srun_ff <= 1'b0;
         pre_ff  <= '0;
      end else if (cmd.sqrt_start) begin
         pre_ff  <= 3'd2;
         srun_ff <= 1'b0;
      end else if (pre_ff != 3'd0) begin
         pre_ff <= pre_ff - 1'b1;
         if (pre_ff == 3'd1) begin
            rad_ff  <= sumsq;
            rem_ff  <= '0;
            root_ff <= '0;
            sbit_ff <= 5'd16;
            srun_ff <= 1'b1;
         end
      end else if (srun_ff) begin
         if ({rem_ff, rad_ff[2*sbit_ff+1 -: 2]} >= {16'd0, root_ff, 2'b01}) begin
            rem_ff  <= 34'({rem_ff, rad_ff[2*sbit_ff+1 -: 2]} - {16'd0, root_ff, 2'b01});
            root_ff <= {root_ff[16:0], 1'b1};
         end else begin
            rem_ff  <= {rem_ff[31:0], rad_ff[2*sbit_ff+1 -: 2]};
            root_ff <= {root_ff[16:0], 1'b0};
         end
         if (sbit_ff == 5'd0) srun_ff <= 1'b0;
         else sbit_ff <= sbit_ff - 1'b1;
      end
   end
   assign stat.sqrt_done = srun_ff && (sbit_ff == 5'd0);

   // deviation from gravity
   logic [17:0] dev;
   logic        mv_next;
   always_comb begin
      if (root_ff >= {3'd0, gravity_mg}) dev = root_ff - {3'd0, gravity_mg};
      else dev = {3'd0, gravity_mg} - root_ff;
      if (moving_ff) mv_next = !(dev < {2'd0, stop_thr});
      else           mv_next = (dev > {2'd0, start_thr});
   end

   logic [31:0] tick_new;
   assign tick_new = tick_ff + 32'(nbatch_ff);

   // phase step and capture copy
   logic [6:0] fill_nx;
   assign fill_nx = fill_ff + 1'b1;
   assign stat.copy_more = capt_ff && (cptr_ff != nbatch_ff) && (fill_ff < win_eff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_PENDING;
         moving_ff    <= 1'b0;
         still_run_ff <= '0;
         fill_ff      <= '0;
         tick_ff      <= '0;
         still_t_ff   <= '0;
         ready_t_ff   <= '0;
         repos_t_ff   <= '0;
         armed_ff     <= 1'b0;
         changed_ff   <= 1'b1;
         done_ff      <= 1'b0;
         capt_ff      <= 1'b0;
         cptr_ff      <= '0;
      end else begin
         if (cmd.arm) armed_ff <= 1'b1;
         if (cmd.finish) done_ff <= 1'b0;
         if (cmd.decide) begin
            changed_ff <= 1'b0;
            done_ff    <= 1'b0;
            capt_ff    <= 1'b0;
            cptr_ff    <= '0;
            tick_ff    <= tick_new;
            moving_ff  <= mv_next;
            unique case (phase_ff)
               PH_PENDING: begin
                  if (!mv_next) begin
                     if (still_run_ff != 10'd1023) still_run_ff <= still_run_ff + 1'b1;
                     if ((still_run_ff == 10'd1023 ? still_run_ff : still_run_ff + 1'b1)
                         >= still_batches) begin
                        phase_ff   <= PH_STILL;
                        changed_ff <= 1'b1;
                        still_t_ff <= tick_new;
                     end
                  end else begin
                     still_run_ff <= '0;
                  end
               end
               PH_STILL: begin
                  if (mv_next) begin
                     phase_ff     <= PH_PENDING;
                     changed_ff   <= 1'b1;
                     still_run_ff <= '0;
                  end else if (tick_new - still_t_ff >= {22'd0, still_hold}) begin
                     phase_ff   <= PH_READY;
                     changed_ff <= 1'b1;
                     ready_t_ff <= tick_new;
                  end
               end
               PH_READY: begin
                  if (armed_ff && (tick_new - ready_t_ff >= READY_MIN_DWELL)) begin
                     armed_ff   <= 1'b0;
                     phase_ff   <= PH_CAPTURE;
                     changed_ff <= 1'b1;
                     fill_ff    <= '0;
                     capt_ff    <= 1'b1;
                  end
               end
               PH_CAPTURE: begin
                  capt_ff <= 1'b1;
               end
               default: begin
                  if (tick_new - repos_t_ff >= {22'd0, repos_wait}) begin
                     phase_ff     <= PH_PENDING;
                     changed_ff   <= 1'b1;
                     still_run_ff <= '0;
                     moving_ff    <= 1'b0;
                     fill_ff      <= '0;
                  end
               end
            endcase
         end else if (cmd.copy_step) begin
            cptr_ff <= cptr_ff + 1'b1;
            fill_ff <= fill_nx;
            if (fill_nx >= win_eff) begin
               phase_ff   <= PH_REPOS;
               changed_ff <= 1'b1;
               repos_t_ff <= tick_ff;
               done_ff    <= 1'b1;
               capt_ff    <= 1'b0;
            end
         end
      end
   end

   // window store write
   always_ff @(posedge clock) begin
      if (cmd.copy_step) win_mem[fill_ff[WA-1:0]] <= batch_mem[cptr_ff[BA-1:0]];
   end

   // window read, registered
   always_ff @(posedge clock) begin
      if (cmd.read_win) rd_ff <= win_mem[req_index[WA-1:0]];
      if (cmd.read_win) cp_valid_ff <= ({1'b0, req_index} < fill_ff) &&
                                       ({26'd0, req_index} < WINDOW_MAX);
      else if (cmd.finish) cp_valid_ff <= 1'b0;
   end

   assign rd_data = cp_valid_ff ? rd_ff : 48'd0;
   assign phase   = phase_ff;
   assign changed = changed_ff;
   assign done    = done_ff;
   assign moving  = moving_ff;
   assign fill    = fill_ff;

endmodule
